FILE: hw/rtl/utf8cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cm_pkg
// shared types, constants and byte classification functions for the
// utf-8 latin-1 case mapper
// ----------------------------------------------------------------------------
package utf8cm_pkg;

  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;
  localparam int LEFT_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEFT_W-1:0] left_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS  = 2'd0,
    MODE_UPPER = 2'd1,
    MODE_LOWER = 2'd2,
    MODE_CAP   = 2'd3
  } mode_t;

  localparam mode_t MODE_RESET = MODE_PASS;

  localparam byte_t LATIN_LEAD  = 8'hC3;
  localparam byte_t CASE_OFFSET = 8'h20;
  localparam logic [5:0] CONT_BITS  = 6'h3F;
  localparam logic [1:0] CONT_TAG   = 2'b10;
  // latin-1 letter ranges, as the low six bits of the second byte
  localparam logic [5:0] UPPER_LAST  = 6'h1E;
  localparam logic [5:0] MUL_SIGN    = 6'h17;
  localparam logic [5:0] LOWER_FIRST = 6'h20;
  localparam logic [5:0] LOWER_LAST  = 6'h3E;
  localparam logic [5:0] DIV_SIGN    = 6'h37;

  // per-unit state carried from byte to byte
  typedef struct packed {
    left_t bytes_left;
    logic  latin_lead;
    logic  to_upper;
    logic  word_start;
  } unit_state_t;

  localparam unit_state_t UNIT_STATE_RESET = '{
    bytes_left: '0, latin_lead: 1'b0, to_upper: 1'b0, word_start: 1'b1
  };

  // bytes that follow a lead byte in its unit
  function automatic left_t follow_bytes(input byte_t b);
    left_t r;
    if (b[7] == 1'b0) begin
      r = 2'd0;
    end else if (b[7:5] == 3'b110) begin
      r = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      r = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      r = 2'd3;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  function automatic logic is_space(input byte_t b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic byte_t map_ascii(input byte_t b, input logic up);
    byte_t r;
    r = b;
    if (up && b >= 8'h61 && b <= 8'h7A) begin
      r = b - CASE_OFFSET;
    end else if (!up && b >= 8'h41 && b <= 8'h5A) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic byte_t map_latin(input byte_t b, input logic up);
    logic [5:0] low6;
    logic       is_up;
    logic       is_low;
    byte_t      r;
    low6   = b[5:0] & CONT_BITS;
    is_up  = (low6 <= UPPER_LAST) && (low6 != MUL_SIGN);
    is_low = (low6 >= LOWER_FIRST) && (low6 <= LOWER_LAST) && (low6 != DIV_SIGN);
    r = b;
    if (up && is_low) begin
      r = {CONT_TAG, 1'b0, low6[4:0]};
    end else if (!up && is_up) begin
      r = {CONT_TAG, 1'b1, low6[4:0]};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/utf8cm_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cm_mapper
// per-byte case mapping logic with the unit and word tracking state
// ----------------------------------------------------------------------------
module utf8cm_mapper
  import utf8cm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  byte_t byte_i,
  input  logic  last_i,
  input  mode_t mode_i,
  output byte_t byte_o
);

  unit_state_t st_r, st_nxt;
  byte_t       mapped;
  left_t       follow;
  logic        up;

  always_comb begin
    st_nxt = st_r;
    mapped = byte_i;
    follow = follow_bytes(byte_i);
    up     = 1'b0;
    if (st_r.bytes_left != '0) begin
      // inside a unit: only the byte after a latin lead maps
      if (st_r.latin_lead) begin
        mapped = map_latin(byte_i, st_r.to_upper);
      end
      st_nxt.latin_lead = 1'b0;
      st_nxt.bytes_left = st_r.bytes_left - 2'd1;
    end else if (mode_i == MODE_CAP && follow == '0 && is_space(byte_i)) begin
      st_nxt.word_start = 1'b1;
    end else begin
      up = (mode_i == MODE_UPPER) || (mode_i == MODE_CAP && st_r.word_start);
      if (mode_i == MODE_CAP) begin
        st_nxt.word_start = 1'b0;
      end
      if (follow == '0) begin
        if (mode_i != MODE_PASS) begin
          mapped = map_ascii(byte_i, up);
        end
      end else begin
        st_nxt.bytes_left = follow;
        st_nxt.latin_lead = (mode_i != MODE_PASS) && (byte_i == LATIN_LEAD);
        st_nxt.to_upper   = up;
      end
    end
    if (last_i) begin
      st_nxt = UNIT_STATE_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= UNIT_STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign byte_o = mapped;

endmodule

FILE: hw/rtl/utf8_latin1_case_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_latin1_case_mapper_top
// streaming utf-8 case mapper for ascii and latin-1 letters
// ----------------------------------------------------------------------------
// Takes one utf-8 byte per request and returns one mapped byte per request,
// in order, with tlast copied through. Throughput is one byte per clock while
// the receiver holds out_tready high; a byte moves from the input register
// to the output register, where it is offered until taken. The path is an
// input register, the mapping logic of utf8cm_mapper, and an output register;
// the input side stays ready while the output register is empty or being
// drained. Mode 0 passes bytes, 1 upper case, 2 lower case, 3 capitalizes
// words (ascii whitespace starts a word). Change the mode only when the block
// is idle. tlast returns all unit and word tracking to its reset state.
module utf8_latin1_case_mapper_top
  import utf8cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [MODE_W-1:0] cfg_wr_data,   // [1:0] mode
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,      // [7:0] in_byte
  input  logic              in_tlast,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,     // [7:0] out_byte
  output logic              out_tlast
);

  // mode register
  mode_t mode_r;

  // input stage
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_last_r;

  // output stage
  logic  s2_valid_r;
  byte_t s2_byte_r;
  logic  s2_last_r;

  byte_t mapped;
  logic  s1_move;
  logic  in_take;

  // input stage empties whenever the output register can take its byte
  assign s1_move   = s1_valid_r && (!s2_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_wr_data);
    end
  end

  // state advances exactly once per byte, as it leaves the input stage
  utf8cm_mapper u_mapper (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_move),
    .byte_i  (s1_byte_r),
    .last_i  (s1_last_r),
    .mode_i  (mode_r),
    .byte_o  (mapped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_r <= 1'b1;
      end else if (out_tready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_move) begin
      s2_byte_r <= mapped;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = s2_byte_r;
  assign out_tlast  = s2_last_r;

endmodule

FILE: hw/rtl/utf8cm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cm_checker
// port-level checks on the case mapper, bound to the top level
// ----------------------------------------------------------------------------
module utf8cm_checker
  import utf8cm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata,
  input logic              out_tlast
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a result appears only after a request has passed through the input and output registers
  a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching request");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind utf8_latin1_case_mapper_top utf8cm_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: dv/tb_utf8_latin1_case_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_latin1_case_mapper_top
// self-checking testbench for the streaming utf-8 latin-1 case mapper
// ----------------------------------------------------------------------------
// Every accepted input byte is run through a behavioral model of the mapper
// kept here (unit tracking, latin-1 pair mapping, word capitalization), and
// the predicted byte and tlast are queued. A monitor compares each accepted
// output request with the oldest prediction. The mode is written only while
// the block is drained. Directed strings cover the ascii and latin-1 letter
// edges, truncated units, mode changes inside a unit and capitalization;
// random text of mixed unit lengths follows under every mode, with bursty
// input traffic, a stalling receiver and one long output hold.
// ----------------------------------------------------------------------------
module tb_utf8_latin1_case_mapper_top;
  import utf8cm_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE       = 4;     // pipeline is two deep, keep some margin
  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
  localparam int STUCK_LIMIT  = 3000;  // cycles with no request moving
  localparam int RANDOM_ITEMS = 800;
  localparam int MAX_REPORTS  = 40;

  localparam byte_t LEAD_C3   = 8'hC3;
  localparam byte_t CASE_STEP = 8'h20;

  // receiver stall styles
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_RUNS
  } ready_style_t;

  // one predicted output request
  typedef struct packed {
    byte_t data;
    logic  last;
  } mapped_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [MODE_W-1:0] cfg_wr_data = MODE_PASS;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata    = '0;     // [7:0] in_byte
  logic              in_tlast    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [BYTE_W-1:0] out_tdata;            // [7:0] out_byte
  logic              out_tlast;

  // model state
  mode_t cur_mode    = MODE_PASS;
  left_t pend_follow = '0;    // continuation bytes still due in this unit
  logic  pend_latin  = 1'b0;  // unit led by 0xc3 and to be mapped
  logic  pend_up     = 1'b0;  // case direction of the open unit
  logic  word_head   = 1'b1;  // next unit opens a word

  mapped_t mapped_bytes[$];
  byte_t   text_buf[$];
  int      mismatches = 0;

  // sender burst shaping
  logic bursty     = 1'b1;
  int   burst_left = 0;

  // receiver pattern state, owned by the receiver process
  int           hold_req   = 0;
  int           hold_ack   = 0;
  int           hold_left  = 0;
  ready_style_t rd_style   = READY_ALWAYS;
  int           style_left = 0;
  int           run_left   = 0;
  logic         run_val    = 1'b1;

  int stuck_cycles = 0;

  utf8_latin1_case_mapper_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // behavioral model
  // --------------------------------------------------------------------------

  // continuation bytes implied by a lead byte; anything odd is a single byte
  function automatic left_t tail_count(input byte_t b);
    if (b[7] == 1'b0)          return 2'd0;
    if (b[7:5] == 3'b110)      return 2'd1;
    if (b[7:4] == 4'b1110)     return 2'd2;
    if (b[7:3] == 5'b11110)    return 2'd3;
    return 2'd0;
  endfunction

  function automatic logic blank_byte(input byte_t b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic byte_t ascii_case(input byte_t b, input logic up);
    if (up && b >= 8'h61 && b <= 8'h7A) return b - CASE_STEP;
    if (!up && b >= 8'h41 && b <= 8'h5A) return b + CASE_STEP;
    return b;
  endfunction

  // second byte of a 0xc3 pair; only the low six bits pick the code point
  function automatic byte_t latin_case(input byte_t b, input logic up);
    byte_t cp;
    logic  cap_letter;
    logic  small_letter;
    cp           = {2'b11, b[5:0]};
    cap_letter   = (cp <= 8'hDE) && (cp != 8'hD7);
    small_letter = (cp >= 8'hE0) && (cp <= 8'hFE) && (cp != 8'hF7);
    if (up && small_letter) return 8'h80 | ((b - CASE_STEP) & 8'h3F);
    if (!up && cap_letter) return 8'h80 | ((b + CASE_STEP) & 8'h3F);
    return b;
  endfunction

  // advances the model by one byte and returns the mapped byte
  function automatic byte_t case_map_byte(input byte_t b, input logic last);
    byte_t o;
    left_t tail;
    logic  up;
    o = b;
    if (pend_follow != '0) begin
      if (pend_latin) o = latin_case(b, pend_up);
      pend_latin  = 1'b0;
      pend_follow = pend_follow - 2'd1;
    end else begin
      tail = tail_count(b);
      if (cur_mode == MODE_CAP && tail == '0 && blank_byte(b)) begin
        word_head = 1'b1;
      end else begin
        up = 1'b0;
        if (cur_mode == MODE_UPPER) begin
          up = 1'b1;
        end else if (cur_mode == MODE_CAP) begin
          up        = word_head;
          word_head = 1'b0;
        end
        if (tail == '0) begin
          if (cur_mode != MODE_PASS) o = ascii_case(b, up);
        end else begin
          pend_follow = tail;
          pend_latin  = (cur_mode != MODE_PASS) && (b == LEAD_C3);
          pend_up     = up;
        end
      end
    end
    // end of string clears all unit and word tracking, mode stays
    if (last) begin
      pend_follow = '0;
      pend_latin  = 1'b0;
      pend_up     = 1'b0;
      word_head   = 1'b1;
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offers one byte and waits for the request to be taken
  task automatic send_byte(input byte_t b, input logic last);
    int gap;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    mapped_bytes.insert(mapped_bytes.size(), '{data: case_map_byte(b, last), last: last});
  endtask

  // sends text_buf as one string, tlast on its final byte
  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // waits until every predicted byte has come back and the pipe is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (mapped_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_mode = m;
  endtask

  // appends one byte at the end of the text buffer
  function automatic void add_byte(input byte_t b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  // appends one random character, mostly well formed, some raw noise
  function automatic void append_char();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = $urandom_range(0, 25);
      add_byte(($urandom_range(0, 1) != 0) ? byte_t'(8'h41 + n) : byte_t'(8'h61 + n));
    end else if (pick < 42) begin
      add_byte(($urandom_range(0, 2) == 0) ? 8'h20 : byte_t'(8'h09 + $urandom_range(0, 4)));
    end else if (pick < 50) begin
      add_byte(byte_t'($urandom_range(0, 127)));
    end else if (pick < 75) begin
      add_byte(LEAD_C3);
      add_byte(byte_t'(8'h80 + $urandom_range(0, 63)));
    end else if (pick < 81) begin
      add_byte(byte_t'(8'hC0 + $urandom_range(0, 31)));
      add_byte(byte_t'(8'h80 + $urandom_range(0, 63)));
    end else if (pick < 87) begin
      add_byte(byte_t'(8'hE0 + $urandom_range(0, 15)));
      repeat (2) add_byte(byte_t'(8'h80 + $urandom_range(0, 63)));
    end else if (pick < 92) begin
      add_byte(byte_t'(8'hF0 + $urandom_range(0, 7)));
      repeat (3) add_byte(byte_t'(8'h80 + $urandom_range(0, 63)));
    end else begin
      add_byte(byte_t'($urandom_range(0, 255)));
    end
  endfunction

  // builds a random string, sometimes cut off inside a unit
  function automatic void build_text(input int target);
    int cut;
    while (text_buf.size() < target) append_char();
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, text_buf.size());
      while (text_buf.size() > cut) void'(text_buf.pop_back());
    end
  endfunction

  // --------------------------------------------------------------------------
  // receiver side: its own stall pattern, plus a long hold on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rd_style   = ready_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      case (rd_style)
        READY_ALWAYS: begin
          out_tready <= 1'b1;
        end
        READY_COIN: begin
          out_tready <= ($urandom_range(0, 1) != 0);
        end
        READY_SPARSE: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (run_left == 0) begin
            run_val  = ~run_val;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          out_tready <= run_val;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result check: each output request against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    mapped_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (mapped_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected output request, data %02h last %0b",
                   $time, out_tdata, out_tlast);
      end else begin
        want = mapped_bytes.pop_front();
        if (out_tdata !== want.data) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: out_byte mismatch, expected %02h actual %02h",
                     $time, want.data, out_tdata);
        end
        if (out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: out_last mismatch, expected %0b actual %0b",
                     $time, want.last, out_tlast);
        end
      end
    end
  end

  // watchdog: no request moving on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[utf8_latin1_case_mapper_top] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // ascii letter edges and a latin-1 pair in upper and lower mode
  task automatic test_ascii_and_latin();
    write_mode(MODE_UPPER);
    // a, z, @, 0xff, a-grave, division sign (kept)
    text_buf = '{8'h61, 8'h7A, 8'h40, 8'hFF, 8'hC3, 8'hA0, 8'hC3, 8'hB7};
    send_text();
    write_mode(MODE_LOWER);
    // A, Z, [, thorn, then 0xc3 followed by a plain ascii byte
    text_buf = '{8'h41, 8'h5A, 8'h5B, 8'hC3, 8'h9E, 8'hC3, 8'h41};
    send_text();
  endtask

  // word starts on whitespace, a latin-1 word head, truncated 4-byte unit
  task automatic test_capitalize_words();
    write_mode(MODE_CAP);
    text_buf = '{8'h20, 8'h61, 8'h42, 8'h0D, 8'hC3, 8'hA9, 8'h41, 8'h80, 8'hF0};
    send_text();
  endtask

  // the mode at the lead byte rules the whole unit
  task automatic test_mode_change_in_unit();
    write_mode(MODE_PASS);
    send_byte(LEAD_C3, 1'b0);
    write_mode(MODE_UPPER);
    send_byte(8'hA0, 1'b1);
    send_byte(LEAD_C3, 1'b0);
    write_mode(MODE_PASS);
    send_byte(8'hA0, 1'b1);
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_output_hold();
    write_mode(MODE_CAP);
    bursty = 1'b0;
    hold_req++;
    @(posedge clk);
    build_text(48);
    send_text();
    bursty = 1'b1;
  endtask

  // random text under every mode, extremes first
  task automatic test_random_text();
    mode_t order[4];
    int    sent;
    order = '{MODE_PASS, MODE_CAP, MODE_UPPER, MODE_LOWER};
    for (int ph = 0; ph < 8; ph++) begin
      write_mode((ph < 4) ? order[ph] : mode_t'($urandom_range(0, 3)));
      sent = 0;
      while (sent < RANDOM_ITEMS / 8) begin
        build_text($urandom_range(1, 20));
        sent += text_buf.size();
        send_text();
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ascii_and_latin();
    test_capitalize_words();
    test_mode_change_in_unit();
    test_output_hold();
    test_random_text();

    drain();
    if (mismatches == 0) begin
      $display("[utf8_latin1_case_mapper_top] OK");
    end else begin
      $display("[utf8_latin1_case_mapper_top] ERROR");
    end
    $finish;
  end

endmodule
